@@ rtl/etrm_pkg.sv @@
// Shared constants and types for the echo timestamp RTT matcher.
package etrm_pkg;

    localparam int HISTORY_DEPTH = 32;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int STAMP_W       = 32;
    localparam int TIME_W        = 64;
    localparam int ENTRY_W       = STAMP_W + TIME_W;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        OP_SEND   = 2'd0,
        OP_STATUS = 2'd1,
        OP_TELEM  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_PEER = 2'd1,
        ST_BAD_LEN = 2'd2,
        ST_BAD_ID  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_PEER    = 2'd0,
        CFG_MAGIC   = 2'd1,
        CFG_VERSION = 2'd2,
        CFG_LENGTH  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        peer_ready;
        logic [31:0] magic;
        logic [7:0]  version;
        logic [7:0]  length;
    } t_cfg;

endpackage

@@ rtl/etrm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module etrm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/etrm_core.sv @@
// Sequencer: send recording, counters, newest-first history scan and result register.
module etrm_core import etrm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [31:0]        i_stamp_ms,
    input  logic [63:0]        i_now_us,
    input  logic               i_send_succeeded,
    input  logic [7:0]         i_packet_length,
    input  logic [31:0]        i_packet_magic,
    input  logic [7:0]         i_packet_version,
    input  logic signed [7:0]  i_peer_rssi,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic               o_match_found,
    output logic [31:0]        o_latest_rtt_us,
    output logic signed [7:0]  o_latest_rssi,
    output logic               o_metrics_valid,
    output logic [31:0]        o_success_total,
    output logic [31:0]        o_fail_total,
    output logic               o_wr_en,
    output t_slot              o_wr_addr,
    output logic [ENTRY_W-1:0] o_wr_data,
    output logic               o_rd_en,
    output t_slot              o_rd_addr,
    input  logic [ENTRY_W-1:0] i_rd_data
);

    localparam t_slot LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

    t_state r_state, n_state;

    logic [HISTORY_DEPTH-1:0] r_valid, n_valid;
    t_slot       r_wslot, n_wslot;
    t_slot       r_slot, n_slot;
    t_cnt        r_cnt, n_cnt;
    logic        r_pend, n_pend;
    logic        r_pend_last, n_pend_last;
    logic        r_vld_q, n_vld_q;
    logic        r_hit, n_hit;
    logic [63:0] r_sent, n_sent;
    logic [31:0] r_stamp, n_stamp;
    logic [63:0] r_now, n_now;
    logic [7:0]  r_in_rssi, n_in_rssi;

    logic [31:0] r_success, n_success;
    logic [31:0] r_fail, n_fail;
    logic [31:0] r_rtt, n_rtt;
    logic [7:0]  r_rssi, n_rssi;
    logic        r_mvalid, n_mvalid;

    logic        r_out_valid, n_out_valid;
    t_status     r_o_status, n_o_status;
    logic        r_o_match, n_o_match;
    logic [31:0] r_o_rtt, n_o_rtt;
    logic [7:0]  r_o_rssi, n_o_rssi;
    logic        r_o_mvalid, n_o_mvalid;
    logic [31:0] r_o_success, n_o_success;
    logic [31:0] r_o_fail, n_o_fail;

    logic        in_fire;
    logic        out_free;
    logic        telem_ok;
    logic        issue;
    logic        hit;
    logic        finish;
    logic [31:0] eff_stamp;
    logic [63:0] eff_time;
    logic [63:0] diff;
    logic        rtt_ok;
    t_op         op;

    assign op         = t_op'(i_opcode);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign telem_ok   = (i_packet_length == i_cfg.length) &&
                        (i_packet_magic == i_cfg.magic) &&
                        (i_packet_version == i_cfg.version);

    assign issue     = (r_state == S_SCAN) && (r_cnt != CNT_W'(HISTORY_DEPTH));
    assign eff_stamp = r_vld_q ? i_rd_data[ENTRY_W-1:TIME_W] : '0;
    assign eff_time  = r_vld_q ? i_rd_data[TIME_W-1:0] : '0;
    assign hit       = r_pend && (eff_stamp == r_stamp);
    assign finish    = r_pend && (hit || r_pend_last);

    assign diff   = r_now - r_sent;
    assign rtt_ok = (r_sent != '0) && (r_now > r_sent) && (diff[63:32] == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && op == OP_TELEM && telem_ok) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (finish) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_valid     = r_valid;
        n_wslot     = r_wslot;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_vld_q     = r_vld_q;
        n_hit       = r_hit;
        n_sent      = r_sent;
        n_stamp     = r_stamp;
        n_now       = r_now;
        n_in_rssi   = r_in_rssi;
        n_success   = r_success;
        n_fail      = r_fail;
        n_rtt       = r_rtt;
        n_rssi      = r_rssi;
        n_mvalid    = r_mvalid;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_status  = r_o_status;
        n_o_match   = r_o_match;
        n_o_rtt     = r_o_rtt;
        n_o_rssi    = r_o_rssi;
        n_o_mvalid  = r_o_mvalid;
        n_o_success = r_o_success;
        n_o_fail    = r_o_fail;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_wslot;
        o_wr_data   = {i_stamp_ms, i_now_us};
        o_rd_en     = 1'b0;
        o_rd_addr   = r_slot;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_o_status = ST_OK;
                    case (op)
                        OP_SEND: begin
                            if (!i_cfg.peer_ready) begin
                                n_o_status = ST_NO_PEER;
                            end else begin
                                o_wr_en          = 1'b1;
                                n_valid[r_wslot] = 1'b1;
                                n_wslot = (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;
                            end
                        end
                        OP_STATUS: begin
                            if (i_send_succeeded) begin
                                n_success = r_success + 32'd1;
                            end else begin
                                n_fail = r_fail + 32'd1;
                            end
                        end
                        OP_TELEM: begin
                            if (i_packet_length != i_cfg.length) begin
                                n_o_status = ST_BAD_LEN;
                            end else if (!telem_ok) begin
                                n_o_status = ST_BAD_ID;
                            end
                        end
                        default: ;
                    endcase
                    if (op == OP_TELEM && telem_ok) begin
                        n_stamp   = i_stamp_ms;
                        n_now     = i_now_us;
                        n_in_rssi = i_peer_rssi;
                        n_slot    = (r_wslot == '0) ? LAST_SLOT : r_wslot - 1'b1;
                        n_cnt     = '0;
                    end else begin
                        n_out_valid = 1'b1;
                        n_o_match   = 1'b0;
                        n_o_rtt     = r_rtt;
                        n_o_rssi    = r_rssi;
                        n_o_mvalid  = r_mvalid;
                        n_o_success = n_success;
                        n_o_fail    = n_fail;
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    o_rd_en     = 1'b1;
                    n_vld_q     = r_valid[r_slot];
                    n_slot      = (r_slot == '0) ? LAST_SLOT : r_slot - 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = (r_cnt == CNT_W'(HISTORY_DEPTH - 1));
                end
                if (finish) begin
                    n_hit  = hit;
                    n_sent = hit ? eff_time : '0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_rtt       = rtt_ok ? diff[31:0] : '0;
                    n_rssi      = r_in_rssi;
                    n_mvalid    = 1'b1;
                    n_out_valid = 1'b1;
                    n_o_status  = ST_OK;
                    n_o_match   = r_hit;
                    n_o_rtt     = n_rtt;
                    n_o_rssi    = r_in_rssi;
                    n_o_mvalid  = 1'b1;
                    n_o_success = r_success;
                    n_o_fail    = r_fail;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_wslot     <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_success   <= '0;
            r_fail      <= '0;
            r_rtt       <= '0;
            r_rssi      <= '0;
            r_mvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_wslot     <= n_wslot;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_success   <= n_success;
            r_fail      <= n_fail;
            r_rtt       <= n_rtt;
            r_rssi      <= n_rssi;
            r_mvalid    <= n_mvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_vld_q     <= n_vld_q;
        r_hit       <= n_hit;
        r_sent      <= n_sent;
        r_stamp     <= n_stamp;
        r_now       <= n_now;
        r_in_rssi   <= n_in_rssi;
        r_o_status  <= n_o_status;
        r_o_match   <= n_o_match;
        r_o_rtt     <= n_o_rtt;
        r_o_rssi    <= n_o_rssi;
        r_o_mvalid  <= n_o_mvalid;
        r_o_success <= n_o_success;
        r_o_fail    <= n_o_fail;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_match_found   = r_o_match;
    assign o_latest_rtt_us = r_o_rtt;
    assign o_latest_rssi   = r_o_rssi;
    assign o_metrics_valid = r_o_mvalid;
    assign o_success_total = r_o_success;
    assign o_fail_total    = r_o_fail;

endmodule

@@ rtl/echo_timestamp_rtt_matcher.sv @@
// Top level of the echo timestamp RTT matcher: configuration registers, history RAM, sequencer.
//
// Input channel: i_in_valid / o_in_stall; a beat is taken when valid is high and stall low.
// Output channel: o_out_valid / i_out_stall; every input beat gives exactly one result beat.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index selects
// peer_ready, expected_magic, expected_version or expected_length; write only when idle.
// Send, send-status, rejected telemetry and unused opcodes finish in the accept cycle;
// the result is in the output register the next cycle, one item per cycle.
// Accepted telemetry scans the history RAM newest first, one read per cycle with
// registered read data, over up to HISTORY_DEPTH entries, and stops early on a match.
// No new beat is taken until the scan's result is in the output register.
// While a result waits under i_out_stall, the next input beat is held off,
// and a finished scan holds its result until the output register frees.
// Reset clears counters, metrics, the write slot, config and the per-entry valid bits;
// entries never written read as stamp 0 and time 0. No clearing pass is needed.
module echo_timestamp_rtt_matcher import etrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [31:0]       i_stamp_ms,
    input  logic [63:0]       i_now_us,
    input  logic              i_send_succeeded,
    input  logic [7:0]        i_packet_length,
    input  logic [31:0]       i_packet_magic,
    input  logic [7:0]        i_packet_version,
    input  logic signed [7:0] i_peer_rssi,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic              o_match_found,
    output logic [31:0]       o_latest_rtt_us,
    output logic signed [7:0] o_latest_rssi,
    output logic              o_metrics_valid,
    output logic [31:0]       o_success_total,
    output logic [31:0]       o_fail_total
);

    t_cfg r_cfg, n_cfg;

    logic               wr_en;
    t_slot              wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    t_slot              rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PEER:    n_cfg.peer_ready = i_cfg_data[0];
                CFG_MAGIC:   n_cfg.magic      = i_cfg_data;
                CFG_VERSION: n_cfg.version    = i_cfg_data[7:0];
                CFG_LENGTH:  n_cfg.length     = i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    etrm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    etrm_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_stamp_ms       (i_stamp_ms),
        .i_now_us         (i_now_us),
        .i_send_succeeded (i_send_succeeded),
        .i_packet_length  (i_packet_length),
        .i_packet_magic   (i_packet_magic),
        .i_packet_version (i_packet_version),
        .i_peer_rssi      (i_peer_rssi),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_match_found    (o_match_found),
        .o_latest_rtt_us  (o_latest_rtt_us),
        .o_latest_rssi    (o_latest_rssi),
        .o_metrics_valid  (o_metrics_valid),
        .o_success_total  (o_success_total),
        .o_fail_total     (o_fail_total),
        .o_wr_en          (wr_en),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data)
    );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the echo timestamp RTT matcher: random and directed beats.
module testbench;
    import etrm_pkg::*;

    typedef struct {
        t_op                op;
        logic [31:0]        stamp;
        logic [63:0]        now;
        logic               succeeded;
        logic [7:0]         length;
        logic [31:0]        magic;
        logic [7:0]         version;
        logic signed [7:0]  rssi;
    } t_radio_event;

    typedef struct {
        t_status            status;
        logic               matched;
        logic [31:0]        rtt;
        logic signed [7:0]  rssi;
        logic               valid;
        logic [31:0]        successes;
        logic [31:0]        failures;
    } t_link_metrics;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index = '0;
    logic [31:0]       i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_opcode = '0;
    logic [31:0]       i_stamp_ms = '0;
    logic [63:0]       i_now_us = '0;
    logic              i_send_succeeded = 1'b0;
    logic [7:0]        i_packet_length = '0;
    logic [31:0]       i_packet_magic = '0;
    logic [7:0]        i_packet_version = '0;
    logic signed [7:0] i_peer_rssi = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_status;
    logic              o_match_found;
    logic [31:0]       o_latest_rtt_us;
    logic signed [7:0] o_latest_rssi;
    logic              o_metrics_valid;
    logic [31:0]       o_success_total;
    logic [31:0]       o_fail_total;

    echo_timestamp_rtt_matcher u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic              cfg_peer_ready = 1'b0;
    logic [31:0]       cfg_magic = '0;
    logic [7:0]        cfg_version = '0;
    logic [7:0]        cfg_length = '0;
    logic [31:0]       hist_stamp [HISTORY_DEPTH] = '{default: '0};
    logic [63:0]       hist_time [HISTORY_DEPTH] = '{default: '0};
    int                next_slot = 0;
    logic [31:0]       success_count = '0;
    logic [31:0]       fail_count = '0;
    logic [31:0]       rtt_latest = '0;
    logic signed [7:0] rssi_latest = '0;
    logic              metrics_seen = 1'b0;

    t_link_metrics     expected_metrics [$];
    logic [31:0]       recent_stamps [$];
    logic [63:0]       recent_times [$];
    logic [63:0]       wall_clock = 64'd1000;
    int                mismatch_count = 0;
    int                outbound_hold = 0;
    bit                sender_steady = 1'b0;
    bit                receiver_steady = 1'b0;

    function automatic t_link_metrics predict_link_metrics(input t_radio_event ev);
        t_link_metrics m;
        logic          hit;
        logic [63:0]   sent_at;
        int            idx;
        int            slot;
        m.status  = ST_OK;
        m.matched = 1'b0;
        case (ev.op)
            OP_SEND: begin
                if (!cfg_peer_ready) begin
                    m.status = ST_NO_PEER;
                end else begin
                    hist_stamp[next_slot] = ev.stamp;
                    hist_time[next_slot]  = ev.now;
                    next_slot = (next_slot + 1) % HISTORY_DEPTH;
                end
            end
            OP_STATUS: begin
                if (ev.succeeded) success_count = success_count + 32'd1;
                else fail_count = fail_count + 32'd1;
            end
            OP_TELEM: begin
                if (ev.length != cfg_length) begin
                    m.status = ST_BAD_LEN;
                end else if (ev.magic != cfg_magic || ev.version != cfg_version) begin
                    m.status = ST_BAD_ID;
                end else begin
                    hit = 1'b0;
                    sent_at = '0;
                    for (idx = 0; idx < HISTORY_DEPTH && !hit; idx++) begin
                        slot = (next_slot + HISTORY_DEPTH - 1 - idx) % HISTORY_DEPTH;
                        if (hist_stamp[slot] == ev.stamp) begin
                            hit = 1'b1;
                            sent_at = hist_time[slot];
                        end
                    end
                    rtt_latest = '0;
                    if (sent_at != 0 && ev.now > sent_at && (ev.now - sent_at) <= 64'hFFFF_FFFF)
                        rtt_latest = 32'(ev.now - sent_at);
                    rssi_latest  = ev.rssi;
                    metrics_seen = 1'b1;
                    m.matched    = hit;
                end
            end
            default: ;
        endcase
        m.rtt       = rtt_latest;
        m.rssi      = rssi_latest;
        m.valid     = metrics_seen;
        m.successes = success_count;
        m.failures  = fail_count;
        return m;
    endfunction

    function automatic t_radio_event rand_event(input t_op op);
        t_radio_event ev;
        ev.op        = op;
        ev.stamp     = $urandom;
        ev.now       = {$urandom, $urandom};
        ev.succeeded = 1'($urandom_range(1));
        ev.length    = 8'($urandom_range(250));
        ev.magic     = $urandom;
        ev.version   = 8'($urandom_range(255));
        ev.rssi      = 8'($urandom_range(255));
        return ev;
    endfunction

    function automatic t_radio_event send_ev(input logic [31:0] stamp, input logic [63:0] now);
        t_radio_event ev;
        ev = rand_event(OP_SEND);
        ev.stamp = stamp;
        ev.now   = now;
        recent_stamps.push_back(stamp);
        recent_times.push_back(now);
        if (recent_stamps.size() > 48) begin
            void'(recent_stamps.pop_front());
            void'(recent_times.pop_front());
        end
        return ev;
    endfunction

    function automatic t_radio_event telem_ev(input logic [31:0] stamp, input logic [63:0] now,
                                              input logic signed [7:0] rssi);
        t_radio_event ev;
        ev = rand_event(OP_TELEM);
        ev.stamp   = stamp;
        ev.now     = now;
        ev.length  = cfg_length;
        ev.magic   = cfg_magic;
        ev.version = cfg_version;
        ev.rssi    = rssi;
        return ev;
    endfunction

    // mostly sends followed by well-formed echoes of recent stamps
    function automatic t_radio_event random_event();
        t_radio_event ev;
        int           pick;
        int           k;
        logic [31:0]  stamp;
        logic [63:0]  base;
        logic [63:0]  now;
        pick = $urandom_range(99);
        if (pick < 35) begin
            wall_clock = wall_clock + 64'($urandom_range(1, 20000));
            if ($urandom_range(19) == 0) wall_clock = {$urandom, $urandom};
            stamp = ($urandom_range(3) == 0) ? 32'($urandom_range(15)) : 32'($urandom);
            return send_ev(stamp, wall_clock);
        end
        if (pick < 45) return rand_event(OP_STATUS);
        if (recent_stamps.size() == 0 || $urandom_range(9) == 0) begin
            stamp = $urandom;
            base  = wall_clock;
        end else begin
            k     = $urandom_range(recent_stamps.size() - 1);
            stamp = recent_stamps[k];
            base  = recent_times[k];
        end
        case ($urandom_range(9))
            6:       now = base + 64'hFFFF_FFFF;
            7:       now = base + 64'h1_0000_0000 + 64'($urandom_range(1));
            8:       now = base;
            9:       now = base - 64'($urandom_range(1, 1000));
            default: now = base + 64'($urandom_range(1, 100000));
        endcase
        ev = telem_ev(stamp, now, 8'($urandom_range(255)));
        if (pick < 80) return ev;
        if (pick < 93) begin
            case ($urandom_range(2))
                0:       ev.length  = 8'((int'(cfg_length) + $urandom_range(1, 250)) % 251);
                1:       ev.magic   = cfg_magic ^ (32'h1 << $urandom_range(31));
                default: ev.version = cfg_version ^ (8'h1 << $urandom_range(7));
            endcase
            return ev;
        end
        if (pick < 97) return rand_event(t_op'($urandom_range(3)));
        return rand_event(OP_NONE);
    endfunction

    // Leaves valid high after the beat is taken; the caller drives again or idles in the same step.
    task automatic drive_event(input t_radio_event ev);
        while (!sender_steady && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= ev.op;
        i_stamp_ms       <= ev.stamp;
        i_now_us         <= ev.now;
        i_send_succeeded <= ev.succeeded;
        i_packet_length  <= ev.length;
        i_packet_magic   <= ev.magic;
        i_packet_version <= ev.version;
        i_peer_rssi      <= ev.rssi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_metrics.push_back(predict_link_metrics(ev));
    endtask

    task automatic wait_for_quiet();
        i_in_valid <= 1'b0;
        while (expected_metrics.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_PEER:    cfg_peer_ready = data[0];
            CFG_MAGIC:   cfg_magic      = data;
            CFG_VERSION: cfg_version    = data[7:0];
            CFG_LENGTH:  cfg_length     = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic peer, input logic [31:0] magic,
                              input logic [7:0] version, input logic [7:0] length);
        write_register(CFG_PEER, {31'b0, peer});
        write_register(CFG_MAGIC, magic);
        write_register(CFG_VERSION, {24'b0, version});
        write_register(CFG_LENGTH, {24'b0, length});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        repeat (count) drive_event(random_event());
    endtask

    task automatic test_unconfigured_defaults();
        t_radio_event ev;
        drive_event(send_ev(32'h0000_1234, 64'd10));
        drive_event(telem_ev(32'd0, 64'd5, 8'sh80));
        drive_event(telem_ev(32'hFFFF_FFFF, 64'd7, 8'sh7F));
        ev = rand_event(OP_STATUS);
        ev.succeeded = 1'b1;
        drive_event(ev);
        ev.succeeded = 1'b0;
        drive_event(ev);
        drive_event(rand_event(OP_NONE));
        ev = telem_ev(32'd0, 64'd9, 8'sh01);
        ev.length = 8'd250;
        drive_event(ev);
        wait_for_quiet();
    endtask

    task automatic test_echo_matching();
        t_radio_event ev;
        set_config(1'b1, 32'hA5A5_5A5A, 8'h01, 8'd32);
        drive_event(send_ev(32'd100, 64'd0));
        drive_event(send_ev(32'd200, 64'd1000));
        drive_event(send_ev(32'hFFFF_FFFF, '1));
        drive_event(send_ev(32'd300, 64'd5000));
        drive_event(send_ev(32'd200, 64'd2000));
        drive_event(telem_ev(32'd100, 64'd50, 8'sh80));
        drive_event(telem_ev(32'd200, 64'd2500, 8'sh7F));
        drive_event(telem_ev(32'hFFFF_FFFF, '1, 8'sh00));
        drive_event(telem_ev(32'd300, 64'd5000 + 64'hFFFF_FFFF, 8'shFF));
        drive_event(telem_ev(32'd300, 64'd5000 + 64'h1_0000_0000, 8'sh01));
        drive_event(telem_ev(32'd300, 64'd4000, 8'sh05));
        drive_event(telem_ev(32'd999, 64'd9000, 8'sh09));
        ev = telem_ev(32'd200, 64'd3000, 8'sh03);
        ev.length = 8'd250;
        drive_event(ev);
        ev = telem_ev(32'd200, 64'd3000, 8'sh03);
        ev.magic = ~cfg_magic;
        drive_event(ev);
        ev = telem_ev(32'd200, 64'd3000, 8'sh03);
        ev.version = 8'hFE;
        drive_event(ev);
        ev.length = 8'd0;
        drive_event(ev);
        wait_for_quiet();
    endtask

    task automatic test_config_sweep();
        set_config(1'b1, $urandom, 8'($urandom_range(255)), 8'($urandom_range(250)));
        run_random(400);
        wait_for_quiet();
        set_config(1'b1, 32'hFFFF_FFFF, 8'hFF, 8'd250);
        run_random(250);
        wait_for_quiet();
        set_config(1'b0, 32'h0, 8'h00, 8'd0);
        run_random(150);
        wait_for_quiet();
        set_config(1'b1, $urandom, 8'($urandom_range(255)), 8'($urandom_range(250)));
        run_random(200);
        wait_for_quiet();
    endtask

    task automatic test_output_holdoff();
        sender_steady = 1'b1;
        outbound_hold = 300;
        run_random(60);
        sender_steady = 1'b0;
        wait_for_quiet();
    endtask

    task automatic test_sender_pause();
        run_random(30);
        wait_for_quiet();
        run_random(30);
        wait_for_quiet();
    endtask

    task automatic test_steady_stream();
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        run_random(200);
        wait_for_quiet();
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_link_metrics want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_metrics.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("%0t: result beat with none pending", $time);
            end else begin
                want = expected_metrics.pop_front();
                check_field("status", want.status, o_status);
                check_field("match_found", want.matched, o_match_found);
                check_field("latest_rtt_us", want.rtt, o_latest_rtt_us);
                check_field("latest_rssi", want.rssi, o_latest_rssi);
                check_field("metrics_valid", want.valid, o_metrics_valid);
                check_field("success_total", want.successes, o_success_total);
                check_field("fail_total", want.failures, o_fail_total);
            end
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (outbound_hold > 0) begin
            i_out_stall <= 1'b1;
            outbound_hold--;
        end else begin
            i_out_stall <= !receiver_steady && ($urandom_range(99) < 30);
        end
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_unconfigured_defaults();
        test_echo_matching();
        test_config_sweep();
        test_output_holdoff();
        test_sender_pause();
        test_steady_stream();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && expected_metrics.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/etrm_pkg.sv
rtl/etrm_ram.sv
rtl/etrm_core.sv
rtl/echo_timestamp_rtt_matcher.sv
verif/testbench.sv
